### design/adg_pkg.sv
// Package with constants, register codes and state encoding for the AdaGrad update block.
package adg_pkg;

    localparam int N_PARAMS   = 4096;
    localparam int IDX_W      = 12;
    localparam int GRAD_W     = 24;
    localparam int RATE_W     = 24;
    localparam int ACC_W      = 48;
    localparam int CNT_W      = 20;
    localparam int ROOT_W     = ACC_W / 2;
    localparam int NUM_W      = 48;
    localparam int DEN_W      = 46;
    localparam int UPD_W      = 32;
    localparam int CLR_W      = $clog2(N_PARAMS) + 1;

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd167772;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REG_INITIAL_RATE = 2'd0,
        REG_DECAY_RATE   = 2'd1
    } cfg_reg_t;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_DECAY_MUL = 10'b0000000100,
        S_DECAY_SET = 10'b0000001000,
        S_SQ        = 10'b0000010000,
        S_ACC       = 10'b0000100000,
        S_SQRT      = 10'b0001000000,
        S_DIV_SET   = 10'b0010000000,
        S_DIV       = 10'b0100000000,
        S_DONE      = 10'b1000000000
    } state_t;

endpackage

### design/adagrad_parameter_update.sv
// AdaGrad parameter update: accumulator memory, shared multiplier, sqrt and divider sequencer.
//
// Usage:
//   Input stream s_*: s_tdata = {gradient, param_index} (zero padded), s_tuser = batch_start.
//   Output stream m_*: m_tdata = {update_value, index_out} (zero padded); one result per item.
//   Config port cfg_*: index 0 initial_rate (also loads the current rate), index 1 decay_rate.
//   Write config only while the block is idle.
// Timing:
//   One item at a time. An item runs decay multiply, square, accumulate, square root,
//   divider setup and division before its result is loaded; a batch-start item with nonzero
//   decay first divides the rate. The sequence uses one shared restoring divider and a 24-step bit-pair square root.
//   s_tready is high only while the sequencer is idle, so the next item is not accepted
//   until the result of the previous one has been loaded.
// Reset:
//   rst_n clears control state, sets the rate to its reset value and starts a
//   pass that zeroes all 4096 accumulators; no item is taken meanwhile.
// Stall:
//   The result waits in the output register; a finished item that meets a full,
//   stalled output register waits in its last state until m_tready.
module adagrad_parameter_update
    import adg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [11:0] param_index, [35:12] gradient, rest zero
    input  logic        s_tuser,   // [0] batch_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [11:0] index_out, [43:12] update_value, rest zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [ACC_W-1:0]  acc_mem [N_PARAMS];
    logic [ACC_W-1:0]  rd_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic              neg_reg;
    logic [GRAD_W-1:0] mag_reg;
    logic              start_reg;

    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] decay_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [NUM_W-1:0]  prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ROOT_W+1:0] rem_sq_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_reg;
    logic [5:0]        step_reg;
    logic              dec_phase_reg;
    logic [CLR_W-1:0]  clr_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [UPD_W-1:0]  out_upd_reg;

    logic              accept;
    logic              in_range;
    logic [GRAD_W-1:0] in_grad;
    logic [GRAD_W-1:0] in_mag;
    logic [RATE_W-1:0] mul_a;
    logic [RATE_W-1:0] mul_b;
    logic [NUM_W-1:0]  mul_p;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [ROOT_W+1:0] sq_sh;
    logic [ROOT_W+1:0] sq_trial;
    logic [DEN_W:0]    div_sh;
    logic              div_ge;
    logic [UPD_W-1:0]  upd_val;
    logic              out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_grad  = s_tdata[35:12];
    assign in_mag   = in_grad[GRAD_W-1] ? (~in_grad + 1'b1) : in_grad;
    assign in_range = (32'(idx_reg) < N_PARAMS);
    assign out_free = !out_valid_reg || m_tready;

    // Shared multiplier: operand pair chosen by state
    always_comb
    begin
        unique case (state_reg)
            S_DECAY_MUL:
            begin
                mul_a = decay_reg;
                mul_b = RATE_W'(count_reg);
            end
            S_SQ:
            begin
                mul_a = mag_reg;
                mul_b = mag_reg;
            end
            default:
            begin
                mul_a = rate_reg;
                mul_b = mag_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign acc_sum = {1'b0, rd_reg} + {1'b0, prod_reg};
    assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    assign sq_sh    = {rem_sq_reg[ROOT_W-1:0], acc_reg[ACC_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};

    assign div_sh = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign div_ge = (div_sh >= {1'b0, den_reg});

    // Saturate and negate the quotient; sign is opposite to the gradient
    always_comb
    begin
        if (!in_range)
        begin
            upd_val = '0;
        end
        else if (neg_reg)
        begin
            upd_val = (num_reg > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : num_reg[UPD_W-1:0];
        end
        else
        begin
            upd_val = (num_reg > NUM_W'(33'h80000000)) ? 32'h80000000
                                                        : (~num_reg[UPD_W-1:0] + 1'b1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_W'(N_PARAMS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECAY_MUL;
                end
            end
            S_DECAY_MUL:
            begin
                state_next = (start_reg && decay_reg != '0) ? S_DECAY_SET : S_SQ;
            end
            S_DECAY_SET:
            begin
                state_next = S_DIV;
            end
            S_SQ:
            begin
                state_next = in_range ? S_ACC : S_DONE;
            end
            S_ACC:
            begin
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (step_reg == 6'(ROOT_W - 1))
                begin
                    state_next = S_DIV_SET;
                end
            end
            S_DIV_SET:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 6'(NUM_W - 1))
                begin
                    state_next = dec_phase_reg ? S_SQ : S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Accumulator memory: clear sweep, read on accept, write back after the add
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            acc_mem[clr_reg[CLR_W-2:0]] <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            acc_mem[idx_reg] <= acc_sat;
        end
        if (accept)
        begin
            rd_reg <= acc_mem[s_tdata[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rate_reg      <= RATE_RESET;
            decay_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            dec_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end

            if (cfg_we)
            begin
                if (cfg_addr == REG_INITIAL_RATE)
                begin
                    rate_reg <= cfg_wdata;
                end
                else if (cfg_addr == REG_DECAY_RATE)
                begin
                    decay_reg <= cfg_wdata;
                end
            end

            if (state_reg == S_DECAY_MUL && start_reg && count_reg != COUNT_MAX)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (state_reg == S_DECAY_SET)
            begin
                dec_phase_reg <= 1'b1;
            end

            if (state_reg == S_ACC || state_reg == S_DIV_SET || state_reg == S_DECAY_SET)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_SQRT || state_reg == S_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end

            // The decayed rate never exceeds the old one, so the low bits hold it
            if (state_reg == S_DIV && step_reg == 6'(NUM_W - 1) && dec_phase_reg)
            begin
                rate_reg      <= {num_reg[RATE_W-2:0], div_ge};
                dec_phase_reg <= 1'b0;
            end

            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg   <= s_tdata[IDX_W-1:0];
            neg_reg   <= in_grad[GRAD_W-1];
            mag_reg   <= in_mag;
            start_reg <= s_tuser;
        end

        unique case (state_reg)
            S_DECAY_MUL, S_SQ, S_ACC:
            begin
                prod_reg <= mul_p;
            end
            default:
            begin
            end
        endcase

        if (state_reg == S_DECAY_SET)
        begin
            num_reg <= {rate_reg, {RATE_W{1'b0}}};
            den_reg <= DEN_W'(prod_reg) + (DEN_W'(1) << RATE_W);
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV_SET)
        begin
            num_reg <= prod_reg;
            den_reg <= DEN_W'({root_reg, 8'd0}) + DEN_W'(9'd256);
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? (div_sh - {1'b0, den_reg}) : div_sh;
        end

        if (state_reg == S_ACC)
        begin
            acc_reg    <= acc_sat;
            rem_sq_reg <= '0;
            root_reg   <= '0;
        end
        else if (state_reg == S_SQRT)
        begin
            acc_reg <= {acc_reg[ACC_W-3:0], 2'b00};
            if (sq_sh >= sq_trial)
            begin
                rem_sq_reg <= sq_sh - sq_trial;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_sq_reg <= sq_sh;
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_idx_reg <= idx_reg;
            out_upd_reg <= upd_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_upd_reg, out_idx_reg};

    property p_clear_blocks;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_CLEAR) |-> !s_tready;
    endproperty
    a_clear_blocks: assert property (p_clear_blocks) else $error("input taken during clear");

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n) accept |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("ready right after accept");

    property p_load_only_free;
        @(posedge clk) disable iff (!rst_n)
            (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_upd_reg));
    endproperty
    a_load_only_free: assert property (p_load_only_free)
        else $error("result overwritten while stalled");

    property p_step_bound;
        @(posedge clk) disable iff (!rst_n) (state_reg == S_SQRT) |-> (step_reg < 6'(ROOT_W));
    endproperty
    a_step_bound: assert property (p_step_bound) else $error("sqrt step overrun");

endmodule
